### hw/rtl/ghs_pkg.sv
package ghs_pkg;

	// Field widths of the item and result channels.
	localparam int OP_W   = 2;
	localparam int ID_W   = 16;
	localparam int POS_W  = 20;
	localparam int SNIR_W = 32;

	// A coordinate difference needs one more bit; its square is twice as wide.
	localparam int DIFF_W = POS_W + 1;
	localparam int SQ_W   = 2 * DIFF_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_OWN_NODE_ID = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SNIR_GUARD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SNIR_FLOOR  = 2'd2;

	localparam logic [ID_W-1:0]   OWN_NODE_ID_RST = 16'd0;
	localparam logic [SNIR_W-1:0] SNIR_GUARD_RST  = 32'd655;
	localparam logic [SNIR_W-1:0] SNIR_FLOOR_RST  = 32'd3284;

	// Operation codes on the item channel.
	localparam logic [OP_W-1:0] OP_BEGIN    = 2'd0;
	localparam logic [OP_W-1:0] OP_VISIT    = 2'd1;
	localparam logic [OP_W-1:0] OP_NEIGHBOR = 2'd2;

	// Default size of the visited set.
	localparam int EXCLUDED_SLOTS_DEF = 3;

	// Queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;

	typedef enum logic [1:0] {
		KIND_BEGIN,
		KIND_VISIT,
		KIND_NEIGHBOR,
		KIND_NONE
	} kind_t;

	// One classified item as it sits in the queue.
	typedef struct packed {
		kind_t               kind;
		logic [ID_W-1:0]     node_id;
		logic [POS_W-1:0]    pos_x;
		logic [POS_W-1:0]    pos_y;
		logic [POS_W-1:0]    own_x;
		logic [POS_W-1:0]    own_y;
		logic [SNIR_W-1:0]   snir;
		logic                last;
		logic                origin;
	} entry_t;

	typedef struct packed {
		logic [ID_W-1:0]   own_node_id;
		logic [SNIR_W-1:0] snir_guard;
		logic [SNIR_W-1:0] snir_floor;
	} cfg_t;

endpackage

### hw/rtl/ghs_if.sv
interface ghs_item_if;
	logic                                   valid;
	logic                                   ready;
	logic [ghs_pkg::OP_W-1:0]               operation;
	logic [ghs_pkg::ID_W-1:0]               node_id;
	logic signed [ghs_pkg::POS_W-1:0]       pos_x;
	logic signed [ghs_pkg::POS_W-1:0]       pos_y;
	logic signed [ghs_pkg::POS_W-1:0]       own_x;
	logic signed [ghs_pkg::POS_W-1:0]       own_y;
	logic [ghs_pkg::SNIR_W-1:0]             snir;
	logic                                   last;

	modport source (
		output valid, operation, node_id, pos_x, pos_y, own_x, own_y, snir, last,
		input  ready
	);
	modport sink (
		input  valid, operation, node_id, pos_x, pos_y, own_x, own_y, snir, last,
		output ready
	);
endinterface

interface ghs_result_if;
	logic                         valid;
	logic                         ready;
	logic [ghs_pkg::ID_W-1:0]     next_hop_id;
	logic                         direct_delivery;
	logic                         failed;

	modport source (
		output valid, next_hop_id, direct_delivery, failed,
		input  ready
	);
	modport sink (
		input  valid, next_hop_id, direct_delivery, failed,
		output ready
	);
endinterface

### hw/rtl/ghs_front.sv
module ghs_front (
	input  logic              clk,
	input  logic              arst_n,
	ghs_item_if.sink          item,
	output ghs_pkg::entry_t   head,
	output logic              head_valid,
	input  logic              pop
);

	ghs_pkg::entry_t                   mem_q [ghs_pkg::QUEUE_DEPTH];
	ghs_pkg::entry_t                   entry;
	logic [ghs_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [ghs_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [ghs_pkg::QUEUE_CNT_W-1:0]   count_q;
	logic                              push;
	logic                              take;

	assign item.ready = (count_q != ghs_pkg::QUEUE_CNT_W'(ghs_pkg::QUEUE_DEPTH));
	assign push       = item.valid && item.ready;
	assign head_valid = (count_q != '0);
	assign take       = pop && head_valid;
	assign head       = mem_q[rd_ptr_q];

	// Classify the operation code and flag a destination at the origin.
	always_comb begin
		unique case (item.operation)
			ghs_pkg::OP_BEGIN:    entry.kind = ghs_pkg::KIND_BEGIN;
			ghs_pkg::OP_VISIT:    entry.kind = ghs_pkg::KIND_VISIT;
			ghs_pkg::OP_NEIGHBOR: entry.kind = ghs_pkg::KIND_NEIGHBOR;
			default:              entry.kind = ghs_pkg::KIND_NONE;
		endcase
		entry.node_id = item.node_id;
		entry.pos_x   = item.pos_x;
		entry.pos_y   = item.pos_y;
		entry.own_x   = item.own_x;
		entry.own_y   = item.own_y;
		entry.snir    = item.snir;
		entry.last    = item.last;
		entry.origin  = (item.pos_x == '0) && (item.pos_y == '0);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + ghs_pkg::QUEUE_PTR_W'(1);
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + ghs_pkg::QUEUE_PTR_W'(1);
			end
			if (push && !take) begin
				count_q <= count_q + ghs_pkg::QUEUE_CNT_W'(1);
			end else if (take && !push) begin
				count_q <= count_q - ghs_pkg::QUEUE_CNT_W'(1);
			end
		end
	end

endmodule

### hw/rtl/ghs_back.sv
module ghs_back #(
	parameter int EXCLUDED_SLOTS = ghs_pkg::EXCLUDED_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ghs_pkg::cfg_t     cfg,
	input  ghs_pkg::entry_t   head,
	input  logic              head_valid,
	output logic              pop,
	ghs_result_if.source      result
);

	localparam int ID_W   = ghs_pkg::ID_W;
	localparam int POS_W  = ghs_pkg::POS_W;
	localparam int DIFF_W = ghs_pkg::DIFF_W;
	localparam int SQ_W   = ghs_pkg::SQ_W;

	// Stage A state: destination as seen by the filter, and the visited set.
	logic [ID_W-1:0]            dest_id_q;
	logic [POS_W-1:0]           dest_x_q;
	logic [POS_W-1:0]           dest_y_q;
	logic [ID_W-1:0]            excl_ids_q [EXCLUDED_SLOTS];
	logic [EXCLUDED_SLOTS-1:0]  excl_vld_q;

	// Stage A logic.
	logic [EXCLUDED_SLOTS-1:0]  hit_vec;
	logic [EXCLUDED_SLOTS-1:0]  free_oh;
	logic [EXCLUDED_SLOTS-1:0]  min_oh;
	logic [ID_W-1:0]            min_id;
	logic                       any_free;
	logic                       hit;
	logic                       is_begin;
	logic [POS_W-1:0]           ax, ay, bx, by;
	logic [DIFF_W-1:0]          diff_x, diff_y;
	logic [DIFF_W-1:0]          abs_x, abs_y;
	logic                       direct_a;
	logic                       pass_a;
	logic                       snir_low;

	// Pipeline register between stage A and stage B.
	logic                       valid_s1;
	ghs_pkg::kind_t             kind_s1;
	logic [ID_W-1:0]            id_s1;
	logic [SQ_W-1:0]            sqx_s1;
	logic [SQ_W-1:0]            sqy_s1;
	logic                       last_s1;
	logic                       direct_s1;
	logic                       pass_s1;
	logic                       origin_s1;

	// Stage B state: the running choice of the query.
	logic [ID_W-1:0]            dest_id_b_q;
	logic                       origin_q;
	logic [SQ_W-1:0]            own_sq_q;
	logic [SQ_W-1:0]            best_sq_q;
	logic [ID_W-1:0]            best_id_q;
	logic                       have_best_q;
	logic                       direct_q;

	logic [ID_W-1:0]            nxt_dest_id_b;
	logic                       nxt_origin;
	logic [SQ_W-1:0]            nxt_own_sq;
	logic [SQ_W-1:0]            nxt_best_sq;
	logic [ID_W-1:0]            nxt_best_id;
	logic                       nxt_have_best;
	logic                       nxt_direct;
	logic [SQ_W-1:0]            dist_b;
	logic                       progress;

	logic [ID_W-1:0]            res_id;
	logic                       res_direct;
	logic                       res_failed;

	logic                       out_valid_q;
	logic                       out_free;
	logic                       b_go;

	assign out_free = !out_valid_q || result.ready;
	assign b_go     = valid_s1 && (!last_s1 || out_free);
	assign pop      = head_valid && (!valid_s1 || b_go);

	// Visited-set lookup, first free slot and smallest held id.
	always_comb begin
		any_free = 1'b0;
		free_oh  = '0;
		for (int i = 0; i < EXCLUDED_SLOTS; i++) begin
			hit_vec[i] = excl_vld_q[i] && (excl_ids_q[i] == head.node_id);
			free_oh[i] = !excl_vld_q[i] && !any_free;
			any_free   = any_free || !excl_vld_q[i];
		end
		hit = |hit_vec;

		min_id = excl_ids_q[0];
		min_oh = EXCLUDED_SLOTS'(1);
		for (int i = 1; i < EXCLUDED_SLOTS; i++) begin
			if (excl_ids_q[i] < min_id) begin
				min_id    = excl_ids_q[i];
				min_oh    = '0;
				min_oh[i] = 1'b1;
			end
		end
	end

	// A begin item measures this node against the destination; a neighbor
	// item measures the neighbor against the stored destination.
	always_comb begin
		is_begin = (head.kind == ghs_pkg::KIND_BEGIN);
		ax = is_begin ? head.own_x : head.pos_x;
		ay = is_begin ? head.own_y : head.pos_y;
		bx = is_begin ? head.pos_x : dest_x_q;
		by = is_begin ? head.pos_y : dest_y_q;
		diff_x = {ax[POS_W-1], ax} - {bx[POS_W-1], bx};
		diff_y = {ay[POS_W-1], ay} - {by[POS_W-1], by};
		abs_x  = diff_x[DIFF_W-1] ? (~diff_x + DIFF_W'(1)) : diff_x;
		abs_y  = diff_y[DIFF_W-1] ? (~diff_y + DIFF_W'(1)) : diff_y;

		snir_low = (head.snir > cfg.snir_guard) && (head.snir < cfg.snir_floor);
		direct_a = (head.node_id == dest_id_q);
		pass_a   = !direct_a && (head.node_id != cfg.own_node_id) && !hit && !snir_low;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_id_q  <= '0;
			dest_x_q   <= '0;
			dest_y_q   <= '0;
			excl_vld_q <= '0;
		end else if (pop) begin
			if (is_begin) begin
				dest_id_q  <= head.node_id;
				dest_x_q   <= head.pos_x;
				dest_y_q   <= head.pos_y;
				excl_vld_q <= '0;
			end else if (head.kind == ghs_pkg::KIND_VISIT && !hit) begin
				if (any_free) begin
					excl_vld_q <= excl_vld_q | free_oh;
				end
			end
		end
	end

	// Slot contents only matter behind their valid bits.
	always_ff @(posedge clk) begin
		if (pop && head.kind == ghs_pkg::KIND_VISIT && !hit) begin
			for (int i = 0; i < EXCLUDED_SLOTS; i++) begin
				if (any_free) begin
					if (free_oh[i]) begin
						excl_ids_q[i] <= head.node_id;
					end
				end else if (min_oh[i] && (head.node_id > min_id)) begin
					excl_ids_q[i] <= head.node_id;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop) begin
			valid_s1 <= 1'b1;
		end else if (b_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_s1   <= head.kind;
			id_s1     <= head.node_id;
			sqx_s1    <= SQ_W'(abs_x) * SQ_W'(abs_x);
			sqy_s1    <= SQ_W'(abs_y) * SQ_W'(abs_y);
			last_s1   <= head.last;
			direct_s1 <= direct_a;
			pass_s1   <= pass_a;
			origin_s1 <= head.origin;
		end
	end

	// Stage B: progress test, best-choice update and result.
	always_comb begin
		dist_b        = sqx_s1 + sqy_s1;
		nxt_dest_id_b = dest_id_b_q;
		nxt_origin    = origin_q;
		nxt_own_sq    = own_sq_q;
		nxt_best_sq   = best_sq_q;
		nxt_best_id   = best_id_q;
		nxt_have_best = have_best_q;
		nxt_direct    = direct_q;
		progress      = origin_q || (dist_b < own_sq_q);

		unique case (kind_s1) inside
			ghs_pkg::KIND_BEGIN: begin
				nxt_dest_id_b = id_s1;
				nxt_origin    = origin_s1;
				nxt_own_sq    = dist_b;
				nxt_best_sq   = '1;
				nxt_best_id   = '0;
				nxt_have_best = 1'b0;
				nxt_direct    = 1'b0;
			end
			ghs_pkg::KIND_NEIGHBOR: begin
				if (direct_s1) begin
					nxt_direct = 1'b1;
				end else if (pass_s1 && progress && (!have_best_q || dist_b < best_sq_q)) begin
					nxt_best_sq   = dist_b;
					nxt_best_id   = id_s1;
					nxt_have_best = 1'b1;
				end
			end
			ghs_pkg::KIND_VISIT, ghs_pkg::KIND_NONE: begin
			end
			default: begin
			end
		endcase

		if (nxt_direct) begin
			res_id     = nxt_dest_id_b;
			res_direct = 1'b1;
			res_failed = 1'b0;
		end else if (nxt_have_best) begin
			res_id     = nxt_best_id;
			res_direct = 1'b0;
			res_failed = 1'b0;
		end else begin
			res_id     = '0;
			res_direct = 1'b0;
			res_failed = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_id_b_q <= '0;
			origin_q    <= 1'b1;
			own_sq_q    <= '0;
			best_sq_q   <= '1;
			best_id_q   <= '0;
			have_best_q <= 1'b0;
			direct_q    <= 1'b0;
		end else if (b_go) begin
			dest_id_b_q <= nxt_dest_id_b;
			origin_q    <= nxt_origin;
			own_sq_q    <= nxt_own_sq;
			best_sq_q   <= nxt_best_sq;
			best_id_q   <= nxt_best_id;
			have_best_q <= nxt_have_best;
			direct_q    <= nxt_direct;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (b_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (b_go && last_s1) begin
			result.next_hop_id     <= res_id;
			result.direct_delivery <= res_direct;
			result.failed          <= res_failed;
		end
	end

	assign result.valid = out_valid_q;

endmodule

### hw/rtl/greedy_next_hop_select.sv
// Greedy next-hop selector for geographic forwarding.
// Items arrive on the item channel (valid/ready); one transfer carries one item. A query
// opens with a begin item (destination id and position, this node's position), then
// visited-node ids, then neighbor entries. The item flagged last yields one transfer on
// the result channel: the destination itself when it was seen as a neighbor, else the
// passing neighbor closest to the destination, else a failed flag.
// Throughput is one item per clock while the input queue has room. A result is first
// offered once its last item has been written into the input queue and has moved through
// the filter stage (visited-set lookup and coordinate squares) and then the selection
// stage that registers the result.
// When the result receiver stalls, the held result waits in the output register while
// later items keep draining; once the four-entry input queue fills, item ready drops.
// Reset empties the queue and pipeline, returns the three registers on the configuration
// port to their defaults and leaves the query state as after an empty query with the
// destination at the origin. Registers are written through cfg_we, cfg_index and
// cfg_data, by the user only while no item is in flight; the block does not enforce it.
module greedy_next_hop_select #(
	parameter int EXCLUDED_SLOTS = ghs_pkg::EXCLUDED_SLOTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	ghs_item_if.sink                           item,
	ghs_result_if.source                       result,
	input  logic                               cfg_we,
	input  logic [ghs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ghs_pkg::CFG_DATA_W-1:0]     cfg_data
);

	ghs_pkg::cfg_t    cfg_q;
	ghs_pkg::entry_t  head;
	logic             head_valid;
	logic             pop;

	// Configuration registers. Writes to an index past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_node_id <= ghs_pkg::OWN_NODE_ID_RST;
			cfg_q.snir_guard  <= ghs_pkg::SNIR_GUARD_RST;
			cfg_q.snir_floor  <= ghs_pkg::SNIR_FLOOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ghs_pkg::REG_OWN_NODE_ID: cfg_q.own_node_id <= cfg_data[ghs_pkg::ID_W-1:0];
				ghs_pkg::REG_SNIR_GUARD:  cfg_q.snir_guard  <= cfg_data[ghs_pkg::SNIR_W-1:0];
				ghs_pkg::REG_SNIR_FLOOR:  cfg_q.snir_floor  <= cfg_data[ghs_pkg::SNIR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The front classifies items and queues them, so the item channel keeps
	// moving while the back end waits on a stalled result.
	ghs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	// The back end filters each neighbor and keeps the best choice so far.
	ghs_back #(
		.EXCLUDED_SLOTS (EXCLUDED_SLOTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.result     (result)
	);

endmodule
